/* sv/fm_synth_register_volume_filter_defines.svh */
// Assertion macros shared by the volume filter RTL.
`ifndef FM_SYNTH_REGISTER_VOLUME_FILTER_DEFINES_SVH
`define FM_SYNTH_REGISTER_VOLUME_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMVF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fmvf: same-cycle check failed");

// The expression must hold on every enabled clock edge.
`define FMVF_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("fmvf: invariant check failed");

`endif

/* sv/fmvf_pkg.sv */
package fmvf_pkg;

   localparam int LEVEL_SLOTS = 22;
   localparam int CHANNELS    = 9;

   localparam int LEVEL_W     = $clog2(LEVEL_SLOTS);
   localparam int CHAN_W      = $clog2(CHANNELS);
   localparam int INIT_WRITES = 2 * CHANNELS + 1;
   localparam int STEP_W      = $clog2(INIT_WRITES);

   // Synthesizer register map.
   localparam logic [7:0] LEVEL_LO     = 8'h40;
   localparam logic [7:0] LEVEL_HI     = 8'h55;
   localparam logic [7:0] CARRIER_BASE = 8'h43;
   localparam logic [7:0] KEYON_LO     = 8'hB0;
   localparam logic [7:0] KEYON_HI     = 8'hB8;
   localparam logic [7:0] CONN_LO      = 8'hC0;
   localparam logic [7:0] CONN_HI      = 8'hC8;
   localparam logic [7:0] RELEASE_BASE = 8'h80;
   localparam logic [7:0] RELEASE_STOP = 8'hFF;
   localparam logic [7:0] RHYTHM_ADDR  = 8'hBD;
   localparam int         KEYON_BIT    = 5;
   localparam logic [5:0] ATTEN_MAX    = 6'd63;

   // Carrier level sits three slots above the modulator level of a channel.
   localparam logic [LEVEL_W-1:0] CARRIER_SLOT = LEVEL_W'(CARRIER_BASE - LEVEL_LO);

   localparam logic [4:0] CHAN_OFFSET [CHANNELS] = '{
      5'h00, 5'h01, 5'h02, 5'h08, 5'h09, 5'h0A, 5'h10, 5'h11, 5'h12
   };

   typedef enum logic [1:0] {
      CMD_REG_WRITE = 2'd0,
      CMD_SET_ATTEN = 2'd1,
      CMD_SET_QUIET = 2'd2,
      CMD_INIT_STOP = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] reg_addr;
      logic [7:0] reg_data;
      logic [5:0] atten;
      logic       quiet_on;
   } req_item_type;

   typedef struct packed {
      logic [7:0] bus_addr;
      logic [7:0] bus_data;
      logic       last;
   } rsp_item_type;

   // Controller to datapath.
   typedef struct packed {
      logic              take_req;
      logic              emit_replay;
      logic              emit_init;
      logic [CHAN_W-1:0] chan;
      logic              modulator;
      logic [STEP_W-1:0] step;
      logic              last;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic                out_free;
      logic [CHANNELS-1:0] additive;
   } dp_status_type;

   // Adds attenuation to a level byte, saturating the six level bits at 63.
   function automatic logic [7:0] attenuate(input logic [7:0] v, input logic [5:0] a);
      logic [6:0] sum;
      sum = {1'b0, v[5:0]} + {1'b0, a};
      if (sum[6]) begin
         return {2'b00, ATTEN_MAX};
      end
      return {v[7:6], sum[5:0]};
   endfunction

endpackage

/* sv/fmvf_ctrl.sv */
module fmvf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  fmvf_pkg::cmd_type      req_cmd,
   output logic                   req_ready,
   input  fmvf_pkg::dp_status_type status,
   output fmvf_pkg::ctl_cmd_type  ctl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPLAY,
      ST_INIT
   } state_type;

   state_type                       state_ff, state_in;
   logic [fmvf_pkg::CHAN_W-1:0]     chan_ff, chan_in;
   logic                            mod_ff, mod_in;
   logic [fmvf_pkg::STEP_W-1:0]     step_ff, step_in;

   always_comb begin
      state_in      = state_ff;
      chan_in       = chan_ff;
      mod_in        = mod_ff;
      step_in       = step_ff;
      req_ready     = 1'b0;
      ctl           = '0;
      ctl.chan      = chan_ff;
      ctl.modulator = mod_ff;
      ctl.step      = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               ctl.take_req = 1'b1;
               chan_in      = '0;
               mod_in       = 1'b0;
               step_in      = '0;
               case (req_cmd)
                  fmvf_pkg::CMD_SET_ATTEN, fmvf_pkg::CMD_SET_QUIET: state_in = ST_REPLAY;
                  fmvf_pkg::CMD_INIT_STOP:                          state_in = ST_INIT;
                  default:                                          state_in = ST_IDLE;
               endcase
            end
         end
         ST_REPLAY: begin
            if (status.out_free) begin
               ctl.emit_replay = 1'b1;
               if (!mod_ff && status.additive[chan_ff]) begin
                  mod_in = 1'b1;
               end else if (chan_ff == fmvf_pkg::CHAN_W'(fmvf_pkg::CHANNELS - 1)) begin
                  ctl.last = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  chan_in = fmvf_pkg::CHAN_W'(chan_ff + 1'b1);
                  mod_in  = 1'b0;
               end
            end
         end
         ST_INIT: begin
            if (status.out_free) begin
               ctl.emit_init = 1'b1;
               if (step_ff == fmvf_pkg::STEP_W'(fmvf_pkg::INIT_WRITES - 1)) begin
                  ctl.last = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  step_in = fmvf_pkg::STEP_W'(step_ff + 1'b1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= '0;
         mod_ff   <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         mod_ff   <= mod_in;
         step_ff  <= step_in;
      end
   end

endmodule

/* sv/fmvf_datapath.sv */
module fmvf_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  fmvf_pkg::req_item_type  req_item,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   input  fmvf_pkg::ctl_cmd_type   ctl,
   output fmvf_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output fmvf_pkg::rsp_item_type  rsp_item
);

   logic [7:0]                    level_ff [fmvf_pkg::LEVEL_SLOTS];
   logic [fmvf_pkg::CHANNELS-1:0] additive_ff;
   logic [5:0]                    master_ff, master_in;
   logic [5:0]                    saved_ff, saved_in;
   logic                          quiet_ff, quiet_in;
   logic                          disabled_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   fmvf_pkg::rsp_item_type        rsp_item_ff, rsp_item_in;

   logic                          bus_write;
   logic [7:0]                    wr_val;
   logic                          wr_hit;
   logic                          level_we;
   logic [fmvf_pkg::LEVEL_W-1:0]  level_wr_idx;
   logic                          conn_we;
   logic [fmvf_pkg::CHAN_W-1:0]   conn_idx;
   logic [4:0]                    rp_off;
   logic [fmvf_pkg::LEVEL_W-1:0]  rp_idx;
   logic [fmvf_pkg::CHAN_W-1:0]   init_chan;
   logic                          load;

   assign bus_write = ctl.take_req && (req_item.cmd == fmvf_pkg::CMD_REG_WRITE)
                      && !disabled_ff;

   // Register write path: quiet masking, shadow update and attenuation.
   always_comb begin
      wr_val = req_item.reg_data;
      if (quiet_ff && (req_item.reg_addr inside {[fmvf_pkg::KEYON_LO:fmvf_pkg::KEYON_HI]})) begin
         wr_val[fmvf_pkg::KEYON_BIT] = 1'b0;
      end
      level_we     = bus_write &&
                     (req_item.reg_addr inside {[fmvf_pkg::LEVEL_LO:fmvf_pkg::LEVEL_HI]});
      level_wr_idx = fmvf_pkg::LEVEL_W'(req_item.reg_addr - fmvf_pkg::LEVEL_LO);
      conn_we      = bus_write &&
                     (req_item.reg_addr inside {[fmvf_pkg::CONN_LO:fmvf_pkg::CONN_HI]});
      conn_idx     = fmvf_pkg::CHAN_W'(req_item.reg_addr - fmvf_pkg::CONN_LO);
      wr_hit       = 1'b0;
      for (int i = 0; i < fmvf_pkg::CHANNELS; i++) begin
         if (req_item.reg_addr == 8'(fmvf_pkg::CARRIER_BASE + {3'b000, fmvf_pkg::CHAN_OFFSET[i]}))
         begin
            wr_hit = 1'b1;
         end
         if ((req_item.reg_addr == 8'(fmvf_pkg::LEVEL_LO + {3'b000, fmvf_pkg::CHAN_OFFSET[i]}))
             && additive_ff[i]) begin
            wr_hit = 1'b1;
         end
      end
   end

   // Replay and init sources.
   assign rp_off    = fmvf_pkg::CHAN_OFFSET[ctl.chan];
   assign rp_idx    = ctl.modulator ? fmvf_pkg::LEVEL_W'(rp_off)
                                    : fmvf_pkg::LEVEL_W'(rp_off + fmvf_pkg::CARRIER_SLOT);
   assign init_chan = fmvf_pkg::CHAN_W'(ctl.step >> 1);

   // Attenuation state follows the accepted command.
   always_comb begin
      master_in = master_ff;
      saved_in  = saved_ff;
      quiet_in  = quiet_ff;
      if (ctl.take_req) begin
         case (req_item.cmd)
            fmvf_pkg::CMD_SET_ATTEN: master_in = req_item.atten;
            fmvf_pkg::CMD_SET_QUIET: begin
               quiet_in = req_item.quiet_on;
               if (req_item.quiet_on) begin
                  saved_in  = master_ff;
                  master_in = fmvf_pkg::ATTEN_MAX;
               end else begin
                  master_in = saved_ff;
               end
            end
            default: master_in = master_ff;
         endcase
      end
   end

   // Output register.
   always_comb begin
      rsp_item_in = rsp_item_ff;
      load        = 1'b0;
      if (bus_write) begin
         load                 = 1'b1;
         rsp_item_in.bus_addr = req_item.reg_addr;
         rsp_item_in.bus_data = wr_hit ? fmvf_pkg::attenuate(wr_val, master_ff) : wr_val;
         rsp_item_in.last     = 1'b1;
      end else if (ctl.emit_replay) begin
         load                 = 1'b1;
         rsp_item_in.bus_addr = ctl.modulator
                                ? 8'(fmvf_pkg::LEVEL_LO + {3'b000, rp_off})
                                : 8'(fmvf_pkg::CARRIER_BASE + {3'b000, rp_off});
         rsp_item_in.bus_data = fmvf_pkg::attenuate(level_ff[rp_idx], master_ff);
         rsp_item_in.last     = ctl.last;
      end else if (ctl.emit_init) begin
         load = 1'b1;
         if (ctl.step == fmvf_pkg::STEP_W'(fmvf_pkg::INIT_WRITES - 1)) begin
            rsp_item_in.bus_addr = fmvf_pkg::RHYTHM_ADDR;
            rsp_item_in.bus_data = 8'h00;
         end else if (!ctl.step[0]) begin
            rsp_item_in.bus_addr = 8'(fmvf_pkg::KEYON_LO + {4'h0, init_chan});
            rsp_item_in.bus_data = 8'h00;
         end else begin
            rsp_item_in.bus_addr =
               8'(fmvf_pkg::RELEASE_BASE + {3'b000, fmvf_pkg::CHAN_OFFSET[init_chan]});
            rsp_item_in.bus_data = fmvf_pkg::RELEASE_STOP;
         end
         rsp_item_in.last = ctl.last;
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fmvf_pkg::LEVEL_SLOTS; i++) begin
            level_ff[i] <= 8'h00;
         end
         additive_ff  <= '0;
         master_ff    <= '0;
         saved_ff     <= '0;
         quiet_ff     <= 1'b0;
         disabled_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (level_we) begin
            level_ff[level_wr_idx] <= wr_val;
         end
         if (conn_we) begin
            additive_ff[conn_idx] <= wr_val[0];
         end
         if (csr_write_enable) begin
            disabled_ff <= csr_write_data;
         end
         master_ff    <= master_in;
         saved_ff     <= saved_in;
         quiet_ff     <= quiet_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.additive = additive_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_item_ff;

endmodule

/* sv/fm_synth_register_volume_filter.sv */
// Volume filter placed in front of an FM synthesizer's register bus.
//
// Commands arrive on the req_ channel (valid/ready); each command yields zero
// or more bus writes on the rsp_ channel (valid/ready), the final write of a
// command carrying last. The csr_ port sets the write-disable flag and must
// only be written while the block is idle.
//
// A register write's bus write is registered and appears on rsp_ in the
// following cycle (none at all when writes are disabled). Set attenuation and
// set quiet replay the shadowed levels, 9 to 18 writes at one per cycle after
// the accepting cycle while the output is free; init stop emits 19 writes in
// the same manner. The replay sequencer is the limit: one cached level is read
// and attenuated per cycle, while the output is free, through a single output
// stage.
// Synchronous reset clears the level shadow, the connection bits, both
// attenuation values, quiet mode and the write-disable flag. When the
// receiver stalls, the pending transaction is held in the output register and
// the sequencer pauses; no new command is taken until the output can move.
`include "fm_synth_register_volume_filter_defines.svh"

module fm_synth_register_volume_filter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fmvf_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fmvf_pkg::rsp_item_type rsp_item,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data
);

   fmvf_pkg::ctl_cmd_type   ctl;
   fmvf_pkg::dp_status_type status;

   // The controller sequences replays and the init burst; it never sees data.
   fmvf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_item.cmd),
      .req_ready (req_ready),
      .status    (status),
      .ctl       (ctl)
   );

   // The datapath owns all shadow state and the output register.
   fmvf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_item         (req_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .ctl              (ctl),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item)
   );

   // While a replay or init burst is running, no new command may be taken.
   `FMVF_ASSERT_IMPLY(a_no_accept_in_burst, clock, reset, ctl.emit_replay || ctl.emit_init, !req_ready)

   // Only one source may load the output register in a cycle.
   `FMVF_ASSERT_ALWAYS(a_single_load, clock, reset, $onehot0({ctl.take_req, ctl.emit_replay, ctl.emit_init}))

   // A burst write must never overwrite a transaction the receiver has not taken.
   `FMVF_ASSERT_IMPLY(a_no_overwrite, clock, reset, ctl.emit_replay || ctl.emit_init, status.out_free)

endmodule

/* test/fmvf_bus_checker.sv */
module fmvf_bus_checker
   import fmvf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_item,
   input  logic         csr_write_enable,
   input  logic         csr_write_data,
   output int           mismatch_count,
   output int           writes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow of the filter's state, kept in step with every accepted transaction.
   logic [7:0]          level_shadow [LEVEL_SLOTS];
   logic [CHANNELS-1:0] additive_chan;
   logic [5:0]          master_atten;
   logic [5:0]          saved_atten;
   logic                quiet_mode;
   logic                writes_off;

   // Bus writes predicted but not yet seen on the result channel, oldest first.
   rsp_item_type bus_writes_due [$];

   int mismatches = 0;
   int due_count  = 0;

   assign mismatch_count = mismatches;
   assign writes_pending = due_count;

   function automatic logic [7:0] attenuated_level(input logic [7:0] lvl, input logic [5:0] a);
      logic [6:0] low_sum;
      low_sum = {1'b0, lvl[5:0]} + {1'b0, a};
      if (low_sum > 7'd63) begin
         return {2'b00, ATTEN_MAX};
      end
      return lvl + {2'b00, a};
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("%0t: bus write mismatch: %s", $realtime, msg);
   endtask

   task automatic queue_write(input logic [7:0] addr, input logic [7:0] data);
      rsp_item_type w;
      w.bus_addr = addr;
      w.bus_data = data;
      w.last     = 1'b0;
      bus_writes_due.push_back(w);
   endtask

   task automatic replay_levels(input logic [5:0] a);
      int off;
      master_atten = a;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         off = int'(CHAN_OFFSET[ch]);
         queue_write(8'(CARRIER_BASE + off), attenuated_level(level_shadow[off + 3], a));
         if (additive_chan[ch]) begin
            queue_write(8'(LEVEL_LO + off), attenuated_level(level_shadow[off], a));
         end
      end
   endtask

   task automatic predict_register_write(input logic [7:0] addr, input logic [7:0] data);
      logic [7:0] val;
      val = data;
      if (!writes_off) begin
         if (quiet_mode && addr >= KEYON_LO && addr <= KEYON_HI) begin
            val[KEYON_BIT] = 1'b0;
         end
         if (addr >= LEVEL_LO && addr <= LEVEL_HI) begin
            level_shadow[addr - LEVEL_LO] = val;
         end
         if (addr >= CONN_LO && addr <= CONN_HI) begin
            additive_chan[addr - CONN_LO] = val[0];
         end
         if (master_atten != 6'd0) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
               if (addr == 8'(CARRIER_BASE + CHAN_OFFSET[ch])) begin
                  val = attenuated_level(val, master_atten);
               end else if (addr == 8'(LEVEL_LO + CHAN_OFFSET[ch]) && additive_chan[ch]) begin
                  val = attenuated_level(val, master_atten);
               end
            end
         end
         queue_write(addr, val);
      end
   endtask

   task automatic predict_command(input req_item_type t);
      int           queued_at_start;
      rsp_item_type final_write;
      queued_at_start = bus_writes_due.size();
      case (t.cmd)
         CMD_REG_WRITE: begin
            predict_register_write(t.reg_addr, t.reg_data);
         end
         CMD_SET_ATTEN: begin
            replay_levels(t.atten);
         end
         CMD_SET_QUIET: begin
            quiet_mode = t.quiet_on;
            if (t.quiet_on) begin
               saved_atten = master_atten;
               replay_levels(ATTEN_MAX);
            end else begin
               replay_levels(saved_atten);
            end
         end
         CMD_INIT_STOP: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
               queue_write(8'(KEYON_LO + ch), 8'h00);
               queue_write(8'(RELEASE_BASE + CHAN_OFFSET[ch]), RELEASE_STOP);
            end
            queue_write(RHYTHM_ADDR, 8'h00);
         end
         default: ;
      endcase
      if (bus_writes_due.size() > queued_at_start) begin
         final_write      = bus_writes_due.pop_back();
         final_write.last = 1'b1;
         bus_writes_due.push_back(final_write);
      end
   endtask

   task automatic check_bus_write(input rsp_item_type got);
      rsp_item_type want;
      if (bus_writes_due.size() == 0) begin
         report_mismatch($sformatf("unexpected write %h <= %h", got.bus_addr, got.bus_data));
      end else begin
         want = bus_writes_due.pop_front();
         if (got.bus_addr !== want.bus_addr) begin
            report_mismatch($sformatf("address %h, expected %h", got.bus_addr, want.bus_addr));
         end
         if (got.bus_data !== want.bus_data) begin
            report_mismatch($sformatf("data %h at %h, expected %h",
                                      got.bus_data, want.bus_addr, want.bus_data));
         end
         if (got.last !== want.last) begin
            report_mismatch($sformatf("last %b at %h, expected %b",
                                      got.last, want.bus_addr, want.last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVEL_SLOTS; i++) begin
            level_shadow[i] = 8'h00;
         end
         additive_chan = '0;
         master_atten  = 6'd0;
         saved_atten   = 6'd0;
         quiet_mode    = 1'b0;
         writes_off    = 1'b0;
         bus_writes_due.delete();
      end else begin
         if (csr_write_enable) begin
            writes_off = csr_write_data;
         end
         if (req_valid && req_ready) begin
            predict_command(req_item);
         end
         if (rsp_valid && rsp_ready) begin
            check_bus_write(rsp_item);
         end
      end
      due_count <= bus_writes_due.size();
   end

endmodule

/* test/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fmvf_pkg::*;

   // Length of the deliberate result-side stall that backs the block up.
   localparam int HOLD_OFF_CYCLES = 80;

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_ready;
   req_item_type req_item         = '0;
   logic         rsp_valid;
   logic         rsp_ready        = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_write_enable = 1'b0;
   logic         csr_write_data   = 1'b0;

   int mismatch_count;
   int writes_pending;

   // When set, neither side inserts idle cycles, so the block runs flat out.
   bit no_idle      = 1'b0;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit hold_off_due = 1'b0;

   always #1 clock = ~clock;

   fm_synth_register_volume_filter uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // The checker sees exactly what the block sees and keeps its own prediction.
   fmvf_bus_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .writes_pending   (writes_pending)
   );

   function automatic req_item_type command(input cmd_type c, input logic [7:0] addr,
                                            input logic [7:0] data, input logic [5:0] at,
                                            input logic q);
      req_item_type t;
      t.cmd      = c;
      t.reg_addr = addr;
      t.reg_data = data;
      t.atten    = at;
      t.quiet_on = q;
      return t;
   endfunction

   // Random commands, weighted towards register writes that land in the
   // shadowed level, connection and key-on ranges, where the behaviour lives.
   // Fields that the command ignores are still randomised so that every bit
   // of the payload toggles.
   function automatic req_item_type random_command();
      req_item_type t;
      int           pick;
      t.reg_addr = 8'($urandom_range(0, 255));
      t.reg_data = 8'($urandom_range(0, 255));
      t.atten    = 6'($urandom_range(0, 63));
      t.quiet_on = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         t.cmd = CMD_REG_WRITE;
         case ($urandom_range(0, 3))
            0: t.reg_addr = 8'(LEVEL_LO + $urandom_range(0, LEVEL_SLOTS - 1));
            1: t.reg_addr = 8'(CONN_LO + $urandom_range(0, CHANNELS - 1));
            2: t.reg_addr = 8'(KEYON_LO + $urandom_range(0, CHANNELS - 1));
            default: ;
         endcase
      end else if (pick < 78) begin
         t.cmd = CMD_SET_ATTEN;
         // Now and then pick one of the extremes outright.
         if ($urandom_range(0, 3) == 0) begin
            t.atten = ($urandom_range(0, 1) == 0) ? 6'd0 : ATTEN_MAX;
         end
      end else if (pick < 93) begin
         t.cmd = CMD_SET_QUIET;
      end else begin
         t.cmd = CMD_INIT_STOP;
      end
      return t;
   endfunction

   // Offers one transaction on the request side. Any idle gap is taken
   // before valid is raised; once raised, valid and the payload are held
   // until the block accepts. The task returns in the accepting time step,
   // so that a back-to-back transaction keeps valid high without a dip.
   task automatic send_command(input req_item_type cmd_item);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= cmd_item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // The write-disable flag may only change while the block is idle. A
   // register write that is dropped yields no result, so after the last
   // predicted write has drained a few spare cycles are allowed for the
   // block to finish any such transaction still in progress.
   task automatic change_write_disable(input logic writes_off);
      req_valid <= 1'b0;
      @(posedge clock);
      while (writes_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= writes_off;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Result side: for every transaction a random number of stall cycles,
   // then ready is held high until a write is taken. On request it first
   // holds ready low for a long stretch so that the block backs up and
   // stops taking commands while the sender keeps offering them.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         gap = no_idle ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      req_item_type cmd_item;
      int           taken;
      int           target;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Pass-through at the address and data extremes, then
      // fill the level shadow so that replays have something to show.
      send_command(command(CMD_REG_WRITE, 8'h00, 8'h00, 6'd0, 1'b0));
      send_command(command(CMD_REG_WRITE, 8'hFF, 8'hFF, 6'd63, 1'b1));
      send_command(command(CMD_REG_WRITE, 8'h43, 8'hFF, 6'd0, 1'b0));
      send_command(command(CMD_REG_WRITE, 8'h40, 8'hC5, 6'd0, 1'b0));
      send_command(command(CMD_REG_WRITE, 8'hC0, 8'h01, 6'd0, 1'b0));
      send_command(command(CMD_REG_WRITE, 8'h55, 8'h3F, 6'd0, 1'b0));
      send_command(command(CMD_REG_WRITE, 8'h4B, 8'h80, 6'd0, 1'b0));
      // Replay with no attenuation, then with one step: the full-scale
      // levels saturate and lose their upper two bits.
      send_command(command(CMD_SET_ATTEN, 8'h00, 8'h00, 6'd0, 1'b0));
      send_command(command(CMD_SET_ATTEN, 8'h00, 8'h00, 6'd1, 1'b0));
      // Live writes under attenuation: a carrier without saturation, an
      // additive modulator that saturates, then the same modulator once
      // its channel has gone back to serial connection.
      send_command(command(CMD_REG_WRITE, 8'h43, 8'h20, 6'd0, 1'b0));
      send_command(command(CMD_REG_WRITE, 8'h40, 8'hFF, 6'd0, 1'b0));
      send_command(command(CMD_REG_WRITE, 8'hC0, 8'h00, 6'd0, 1'b0));
      send_command(command(CMD_REG_WRITE, 8'h40, 8'h10, 6'd0, 1'b0));
      // Quiet mode: entering saves the attenuation, leaving restores it,
      // and entering twice in a row saves the forced maximum instead.
      send_command(command(CMD_SET_ATTEN, 8'h00, 8'h00, 6'd10, 1'b0));
      send_command(command(CMD_SET_QUIET, 8'h00, 8'h00, 6'd0, 1'b1));
      send_command(command(CMD_SET_QUIET, 8'h00, 8'h00, 6'd0, 1'b0));
      send_command(command(CMD_SET_QUIET, 8'h00, 8'h00, 6'd0, 1'b1));
      send_command(command(CMD_SET_QUIET, 8'h00, 8'h00, 6'd0, 1'b1));
      // Key-on is stripped only inside the key-on range while quiet.
      send_command(command(CMD_REG_WRITE, 8'hB0, 8'hFF, 6'd0, 1'b0));
      send_command(command(CMD_REG_WRITE, 8'hB8, 8'h20, 6'd0, 1'b0));
      send_command(command(CMD_REG_WRITE, 8'hB9, 8'hFF, 6'd0, 1'b0));
      send_command(command(CMD_SET_QUIET, 8'h00, 8'h00, 6'd0, 1'b0));
      send_command(command(CMD_SET_ATTEN, 8'h00, 8'h00, 6'd63, 1'b0));
      send_command(command(CMD_INIT_STOP, 8'h00, 8'h00, 6'd0, 1'b0));
      // With writes disabled a register write vanishes, while replays and
      // the stop sequence still go out.
      change_write_disable(1'b1);
      send_command(command(CMD_REG_WRITE, 8'h43, 8'h11, 6'd0, 1'b0));
      send_command(command(CMD_SET_ATTEN, 8'h00, 8'h00, 6'd5, 1'b0));
      send_command(command(CMD_INIT_STOP, 8'h00, 8'h00, 6'd0, 1'b0));

      // Random part in four phases of equal length. The third runs with
      // writes disabled; the second runs without idle cycles on either side;
      // the first and last each begin with a long stall on the result side.
      for (int phase = 0; phase < 4; phase++) begin
         change_write_disable(phase == 2);
         no_idle = (phase == 1);
         if (phase == 0 || phase == 3) begin
            hold_off_due = 1'b1;
         end
         target = 26;
         taken  = 0;
         while (taken < target) begin
            cmd_item = random_command();
            send_command(cmd_item);
            taken++;
         end
      end

      // Drain: wait for every predicted write, then a little longer to catch
      // any stray transaction that should never have appeared.
      req_valid <= 1'b0;
      @(posedge clock);
      while (writes_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin
      #400000;
      $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/fmvf_pkg.sv
sv/fmvf_ctrl.sv
sv/fmvf_datapath.sv
sv/fm_synth_register_volume_filter.sv
test/fmvf_bus_checker.sv
test/tb.sv
